FILE: rtl/vcrf_pkg.sv
// shared types, register map codes and raster helpers for the video register file
package vcrf_pkg;

    // frame geometry
    localparam int LINES_PER_FRAME = 312;
    localparam int LINE_W          = 9;
    localparam int LINE_MAX        = (1 << LINE_W) - 1;
    // compare-subtract steps needed to fold a raster value into the frame
    localparam int MOD_STEPS       = $clog2(LINE_MAX / LINES_PER_FRAME + 1);

    // operation codes
    localparam logic [2:0] OP_READ      = 3'd0;
    localparam logic [2:0] OP_WRITE     = 3'd1;
    localparam logic [2:0] OP_RMW       = 3'd2;
    localparam logic [2:0] OP_SET_LINE  = 3'd3;
    localparam logic [2:0] OP_TICK      = 3'd4;
    localparam logic [2:0] OP_COLLISION = 3'd5;

    // register map
    localparam logic [5:0] REG_POS_FIRST  = 6'h00;
    localparam logic [5:0] REG_POS_LAST   = 6'h0F;
    localparam logic [5:0] REG_X_MSB      = 6'h10;
    localparam logic [5:0] REG_MODE       = 6'h11;
    localparam logic [5:0] REG_RASTER     = 6'h12;
    localparam logic [5:0] REG_ENABLE     = 6'h15;
    localparam logic [5:0] REG_HCTRL      = 6'h16;
    localparam logic [5:0] REG_Y_EXPAND   = 6'h17;
    localparam logic [5:0] REG_MEM_PTR    = 6'h18;
    localparam logic [5:0] REG_IRQ_STATUS = 6'h19;
    localparam logic [5:0] REG_IRQ_MASK   = 6'h1A;
    localparam logic [5:0] REG_PRIORITY   = 6'h1B;
    localparam logic [5:0] REG_MULTICOL   = 6'h1C;
    localparam logic [5:0] REG_X_EXPAND   = 6'h1D;
    localparam logic [5:0] REG_COLL_SS    = 6'h1E;
    localparam logic [5:0] REG_COLL_SB    = 6'h1F;
    localparam logic [5:0] REG_BORDER     = 6'h20;
    localparam logic [5:0] REG_BG_FIRST   = 6'h21;
    localparam logic [5:0] REG_BG_LAST    = 6'h24;
    localparam logic [5:0] REG_SHARED0    = 6'h25;
    localparam logic [5:0] REG_SHARED1    = 6'h26;
    localparam logic [5:0] REG_SCOL_FIRST = 6'h27;
    localparam logic [5:0] REG_SCOL_LAST  = 6'h2E;
    localparam logic [5:0] REG_KBD_SEL    = 6'h2F;
    localparam logic [5:0] REG_FAST_CLK   = 6'h30;

    // slots of the sprite flag bytes
    localparam logic [2:0] FLAG_X_MSB    = 3'd0;
    localparam logic [2:0] FLAG_ENABLE   = 3'd1;
    localparam logic [2:0] FLAG_Y_EXPAND = 3'd2;
    localparam logic [2:0] FLAG_PRIORITY = 3'd3;
    localparam logic [2:0] FLAG_MULTICOL = 3'd4;
    localparam logic [2:0] FLAG_X_EXPAND = 3'd5;

    // interrupt status bits that can be raised
    localparam int IRQ_RASTER = 0;
    localparam int IRQ_SB     = 1;
    localparam int IRQ_SS     = 2;

    localparam logic [7:0] UNMAPPED_READ = 8'hFF;
    localparam logic [5:0] FAST_CLK_FILL = 6'h3F;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [5:0]        reg_address;
        logic [7:0]        write_data;
        logic [LINE_W-1:0] raster_line;
        logic [7:0]        sprite_hits;
        logic [7:0]        background_hits;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_asserted;
    } t_out;

    // raster value modulo the frame length, by shifted compare-subtract
    function automatic logic [LINE_W-1:0] line_mod(input logic [LINE_W-1:0] line);
        logic [LINE_W-1:0] r;
        r = line;
        for (int k = MOD_STEPS - 1; k >= 0; k--) begin
            if (r >= LINE_W'(LINES_PER_FRAME << k)) begin
                r = r - LINE_W'(LINES_PER_FRAME << k);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/video_chip_register_file_irq.sv
// top level: register file and raster interrupt of a raster video chip
//
// Each transaction is a bus read, write or read-modify-write on one of 64
// register addresses, a set-raster-line event, a raster tick or a collision
// report, and yields exactly one result: the read byte (zero for anything
// but a read) and the interrupt line after the transaction. One transaction
// is taken every cycle while the input side does not stall. A result passes
// the input register, a single decode-and-update pass and the result
// register, and waits there while the output side stalls. The output
// register lets a new transaction enter while a result still waits.
// Collision registers clear on read, status bits are acknowledged by
// writing ones, and unmapped addresses read as 0xFF.
module video_chip_register_file_irq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  vcrf_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output vcrf_pkg::t_out o_out
);

    // pipeline registers
    logic           r_in_valid;
    vcrf_pkg::t_in  r_in;
    logic           r_out_valid;
    vcrf_pkg::t_out r_out;
    logic           w_advance;

    // register file state; the raster byte and mode bit 7 have no register of
    // their own: writes set the compare line and reads return the current line
    logic [7:0]                  r_pos      [16];
    logic [7:0]                  r_flag     [6];
    logic [3:0]                  r_scol     [8];
    logic [3:0]                  r_bgcol    [4];
    logic [3:0]                  r_shared   [2];
    logic [3:0]                  r_border;
    logic [6:0]                  r_mode;
    logic [7:0]                  r_hctrl;
    logic [7:0]                  r_memptr;
    logic [2:0]                  r_status;
    logic [4:0]                  r_mask;
    logic [7:0]                  r_coll_ss;
    logic [7:0]                  r_coll_sb;
    logic [7:0]                  r_kbd;
    logic                        r_fast;
    logic [vcrf_pkg::LINE_W-1:0] r_cmp;
    logic                        r_fired;
    logic [vcrf_pkg::LINE_W-1:0] r_cur;
    logic [vcrf_pkg::LINE_W-1:0] r_prev;

    // next-state values
    logic [7:0]                  n_pos      [16];
    logic [7:0]                  n_flag     [6];
    logic [3:0]                  n_scol     [8];
    logic [3:0]                  n_bgcol    [4];
    logic [3:0]                  n_shared   [2];
    logic [3:0]                  n_border;
    logic [6:0]                  n_mode;
    logic [7:0]                  n_hctrl;
    logic [7:0]                  n_memptr;
    logic [2:0]                  n_status;
    logic [4:0]                  n_mask;
    logic [7:0]                  n_coll_ss;
    logic [7:0]                  n_coll_sb;
    logic [7:0]                  n_kbd;
    logic                        n_fast;
    logic [vcrf_pkg::LINE_W-1:0] n_cmp;
    logic                        n_fired;
    logic [vcrf_pkg::LINE_W-1:0] n_cur;
    logic [vcrf_pkg::LINE_W-1:0] n_prev;
    vcrf_pkg::t_out              n_out;

    logic [7:0] rd_val;
    logic       irq_now;

    // handshake
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign irq_now     = |(r_status & r_mask[2:0]);

    // register read mux on the state before the transaction
    always_comb begin : read_mux
        logic [5:0] off;
        off    = '0;
        rd_val = vcrf_pkg::UNMAPPED_READ;
        unique case (r_in.reg_address) inside
            [vcrf_pkg::REG_POS_FIRST:vcrf_pkg::REG_POS_LAST]:
                rd_val = r_pos[r_in.reg_address[3:0]];
            vcrf_pkg::REG_X_MSB:      rd_val = r_flag[vcrf_pkg::FLAG_X_MSB];
            vcrf_pkg::REG_ENABLE:     rd_val = r_flag[vcrf_pkg::FLAG_ENABLE];
            vcrf_pkg::REG_Y_EXPAND:   rd_val = r_flag[vcrf_pkg::FLAG_Y_EXPAND];
            vcrf_pkg::REG_PRIORITY:   rd_val = r_flag[vcrf_pkg::FLAG_PRIORITY];
            vcrf_pkg::REG_MULTICOL:   rd_val = r_flag[vcrf_pkg::FLAG_MULTICOL];
            vcrf_pkg::REG_X_EXPAND:   rd_val = r_flag[vcrf_pkg::FLAG_X_EXPAND];
            vcrf_pkg::REG_MODE:       rd_val = {r_cur[8], r_mode};
            vcrf_pkg::REG_RASTER:     rd_val = r_cur[7:0];
            vcrf_pkg::REG_HCTRL:      rd_val = r_hctrl;
            vcrf_pkg::REG_MEM_PTR:    rd_val = r_memptr;
            vcrf_pkg::REG_IRQ_STATUS: rd_val = {irq_now, 4'b0, r_status};
            vcrf_pkg::REG_IRQ_MASK:   rd_val = {3'b0, r_mask};
            vcrf_pkg::REG_COLL_SS:    rd_val = r_coll_ss;
            vcrf_pkg::REG_COLL_SB:    rd_val = r_coll_sb;
            vcrf_pkg::REG_BORDER:     rd_val = {4'b0, r_border};
            [vcrf_pkg::REG_BG_FIRST:vcrf_pkg::REG_BG_LAST]: begin
                off    = r_in.reg_address - vcrf_pkg::REG_BG_FIRST;
                rd_val = {4'b0, r_bgcol[off[1:0]]};
            end
            vcrf_pkg::REG_SHARED0:    rd_val = {4'b0, r_shared[0]};
            vcrf_pkg::REG_SHARED1:    rd_val = {4'b0, r_shared[1]};
            [vcrf_pkg::REG_SCOL_FIRST:vcrf_pkg::REG_SCOL_LAST]: begin
                off    = r_in.reg_address - vcrf_pkg::REG_SCOL_FIRST;
                rd_val = {4'b0, r_scol[off[2:0]]};
            end
            vcrf_pkg::REG_KBD_SEL:    rd_val = r_kbd;
            vcrf_pkg::REG_FAST_CLK:   rd_val = {vcrf_pkg::FAST_CLK_FILL, 1'b0, r_fast};
            default:                  rd_val = vcrf_pkg::UNMAPPED_READ;
        endcase
    end

    // one pass of state update for the registered transaction
    always_comb begin : update
        logic [5:0]                  addr;
        logic                        is_rd;
        logic                        w_en;
        logic [7:0]                  w_val;
        logic [5:0]                  off;
        logic [vcrf_pkg::LINE_W-1:0] new_cmp;
        addr      = r_in.reg_address;
        is_rd     = (r_in.opcode == vcrf_pkg::OP_READ) || (r_in.opcode == vcrf_pkg::OP_RMW);
        w_en      = 1'b0;
        w_val     = '0;
        off       = '0;
        new_cmp   = r_cmp;
        n_pos     = r_pos;
        n_flag    = r_flag;
        n_scol    = r_scol;
        n_bgcol   = r_bgcol;
        n_shared  = r_shared;
        n_border  = r_border;
        n_mode    = r_mode;
        n_hctrl   = r_hctrl;
        n_memptr  = r_memptr;
        n_status  = r_status;
        n_mask    = r_mask;
        n_coll_ss = r_coll_ss;
        n_coll_sb = r_coll_sb;
        n_kbd     = r_kbd;
        n_fast    = r_fast;
        n_cmp     = r_cmp;
        n_fired   = r_fired;
        n_cur     = r_cur;
        n_prev    = r_prev;

        // read side effects on the collision latches
        if (is_rd && addr == vcrf_pkg::REG_COLL_SS) begin
            n_coll_ss                  = '0;
            n_status[vcrf_pkg::IRQ_SS] = 1'b0;
        end
        if (is_rd && addr == vcrf_pkg::REG_COLL_SB) begin
            n_coll_sb                  = '0;
            n_status[vcrf_pkg::IRQ_SB] = 1'b0;
        end

        // write passes: read-modify-write writes the read byte back first
        for (int p = 0; p < 2; p++) begin
            if (p == 0) begin
                w_en  = (r_in.opcode == vcrf_pkg::OP_RMW);
                w_val = rd_val;
            end else begin
                w_en  = (r_in.opcode == vcrf_pkg::OP_RMW) ||
                        (r_in.opcode == vcrf_pkg::OP_WRITE);
                w_val = r_in.write_data;
            end
            if (w_en) begin
                unique case (addr) inside
                    [vcrf_pkg::REG_POS_FIRST:vcrf_pkg::REG_POS_LAST]:
                        n_pos[addr[3:0]] = w_val;
                    vcrf_pkg::REG_X_MSB:    n_flag[vcrf_pkg::FLAG_X_MSB]    = w_val;
                    vcrf_pkg::REG_ENABLE:   n_flag[vcrf_pkg::FLAG_ENABLE]   = w_val;
                    vcrf_pkg::REG_Y_EXPAND: n_flag[vcrf_pkg::FLAG_Y_EXPAND] = w_val;
                    vcrf_pkg::REG_PRIORITY: n_flag[vcrf_pkg::FLAG_PRIORITY] = w_val;
                    vcrf_pkg::REG_MULTICOL: n_flag[vcrf_pkg::FLAG_MULTICOL] = w_val;
                    vcrf_pkg::REG_X_EXPAND: n_flag[vcrf_pkg::FLAG_X_EXPAND] = w_val;
                    vcrf_pkg::REG_MODE: begin
                        n_mode  = w_val[6:0];
                        new_cmp = {w_val[7], n_cmp[7:0]};
                        if (new_cmp != n_cmp) begin
                            n_fired = 1'b0;
                        end
                        n_cmp = new_cmp;
                    end
                    vcrf_pkg::REG_RASTER: begin
                        new_cmp = {n_cmp[8], w_val};
                        if (new_cmp != n_cmp) begin
                            n_fired = 1'b0;
                        end
                        n_cmp = new_cmp;
                    end
                    vcrf_pkg::REG_HCTRL:      n_hctrl  = w_val;
                    vcrf_pkg::REG_MEM_PTR:    n_memptr = w_val;
                    vcrf_pkg::REG_IRQ_STATUS: n_status = n_status & ~w_val[2:0];
                    vcrf_pkg::REG_IRQ_MASK:   n_mask   = w_val[4:0];
                    vcrf_pkg::REG_BORDER:     n_border = w_val[3:0];
                    [vcrf_pkg::REG_BG_FIRST:vcrf_pkg::REG_BG_LAST]: begin
                        off                = addr - vcrf_pkg::REG_BG_FIRST;
                        n_bgcol[off[1:0]]  = w_val[3:0];
                    end
                    vcrf_pkg::REG_SHARED0:    n_shared[0] = w_val[3:0];
                    vcrf_pkg::REG_SHARED1:    n_shared[1] = w_val[3:0];
                    [vcrf_pkg::REG_SCOL_FIRST:vcrf_pkg::REG_SCOL_LAST]: begin
                        off               = addr - vcrf_pkg::REG_SCOL_FIRST;
                        n_scol[off[2:0]]  = w_val[3:0];
                    end
                    vcrf_pkg::REG_KBD_SEL:    n_kbd  = w_val;
                    vcrf_pkg::REG_FAST_CLK:   n_fast = w_val[0];
                    default: ;
                endcase
            end
        end

        // raster events and collision reports
        if (r_in.opcode == vcrf_pkg::OP_SET_LINE) begin
            n_cur = vcrf_pkg::line_mod(r_in.raster_line);
        end
        if (r_in.opcode == vcrf_pkg::OP_TICK) begin
            // frame wrap re-arms the compare latch
            if (r_cur < r_prev) begin
                n_fired = 1'b0;
            end
            if (r_cur == r_cmp && !n_fired) begin
                n_status[vcrf_pkg::IRQ_RASTER] = 1'b1;
                n_fired                        = 1'b1;
            end
            n_prev = r_cur;
        end
        if (r_in.opcode == vcrf_pkg::OP_COLLISION) begin
            if (r_in.sprite_hits != '0) begin
                n_coll_ss                  = r_coll_ss | r_in.sprite_hits;
                n_status[vcrf_pkg::IRQ_SS] = 1'b1;
            end
            if (r_in.background_hits != '0) begin
                n_coll_sb                  = r_coll_sb | r_in.background_hits;
                n_status[vcrf_pkg::IRQ_SB] = 1'b1;
            end
        end

        // result of the transaction
        n_out.read_data    = (r_in.opcode == vcrf_pkg::OP_READ) ? rd_val : 8'h00;
        n_out.irq_asserted = |(n_status & n_mask[2:0]);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall) begin
            r_in <= i_in;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    // register file state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '{default: '0};
            r_flag    <= '{default: '0};
            r_scol    <= '{default: '0};
            r_bgcol   <= '{default: '0};
            r_shared  <= '{default: '0};
            r_border  <= '0;
            r_mode    <= 7'h1B;
            r_hctrl   <= 8'h80;
            r_memptr  <= 8'h14;
            r_status  <= '0;
            r_mask    <= '0;
            r_coll_ss <= '0;
            r_coll_sb <= '0;
            r_kbd     <= 8'hFF;
            r_fast    <= 1'b0;
            r_cmp     <= '0;
            r_fired   <= 1'b0;
            r_cur     <= '0;
            r_prev    <= '0;
        end else if (w_advance) begin
            r_pos     <= n_pos;
            r_flag    <= n_flag;
            r_scol    <= n_scol;
            r_bgcol   <= n_bgcol;
            r_shared  <= n_shared;
            r_border  <= n_border;
            r_mode    <= n_mode;
            r_hctrl   <= n_hctrl;
            r_memptr  <= n_memptr;
            r_status  <= n_status;
            r_mask    <= n_mask;
            r_coll_ss <= n_coll_ss;
            r_coll_sb <= n_coll_sb;
            r_kbd     <= n_kbd;
            r_fast    <= n_fast;
            r_cmp     <= n_cmp;
            r_fired   <= n_fired;
            r_cur     <= n_cur;
            r_prev    <= n_prev;
        end
    end

endmodule

FILE: rtl/vcrf_checker.sv
// port-level checks of the video register file, bound to the top level
module vcrf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input vcrf_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input vcrf_pkg::t_out o_out
);

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed or dropped while stalled");

    // a result is only withdrawn after a transaction on the output
    a_out_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(!i_out_stall))
        else $error("result lost without a transaction");

    // input side stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the output could move");

    // reset empties the pipeline
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind video_chip_register_file_irq vcrf_checker u_vcrf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
